>>> rtl/rgp_pkg.sv
// Shared widths, register indexes and step functions for the radial gradient pixel pipeline.
`default_nettype none

package rgp_pkg;

    // Image geometry
    localparam int MAX_SIDE  = 1024;
    localparam int SIDE_W    = 11;
    localparam int COORD_W   = 10;
    localparam int OFF_W     = 11;
    localparam int SQ_W      = 2 * OFF_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int SUM_PAD_W = SUM_W + (SUM_W % 2);

    // Square root of the sum shifted up by 32 bits
    localparam int ROOT_W     = (SUM_PAD_W + 32) / 2;
    localparam int SQ_REM_W   = ROOT_W + 2;
    localparam int SQ_PER_STG = 2;
    localparam int SQ_STG     = ROOT_W / SQ_PER_STG;

    // Blend factor and divider
    localparam int DENS_W      = 16;
    localparam int FACTOR_BITS = 16;
    localparam int ONE_W       = FACTOR_BITS + 1;
    localparam int DEN_W       = SIDE_W + DENS_W;
    localparam int DIV_PER_STG = 2;
    localparam int DIV_STG     = FACTOR_BITS / DIV_PER_STG;

    // Color and bus widths
    localparam int CH_W       = 8;
    localparam int COLOR_W    = 4 * CH_W;
    localparam int OCOLOR_W   = 3 * CH_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_DENS   = 3'd2,
        REG_INNER  = 3'd3,
        REG_OUTER  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic [DEN_W-1:0]       rem;
        logic [FACTOR_BITS-1:0] quo;
    } dv_t;

    // Factor override flags that travel beside the quotient
    typedef struct packed {
        logic one;
        logic zero;
    } fsel_t;

    // One restoring square root step: take the next bit pair, produce one root bit
    function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
        logic [SQ_REM_W+1:0] tmp;
        logic [SQ_REM_W+1:0] trial;
        sq_t                 nxt;
        tmp   = {cur.rem, pair};
        trial = {2'b00, cur.root, 2'b01};
        if (tmp >= trial) begin
            nxt.rem  = SQ_REM_W'(tmp - trial);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = tmp[SQ_REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // One restoring division step: produce one quotient bit
    function automatic dv_t div_step(dv_t cur, logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        dv_t            nxt;
        t = {cur.rem, 1'b0};
        if (t >= {1'b0, den}) begin
            nxt.rem = DEN_W'(t - {1'b0, den});
            nxt.quo = {cur.quo[FACTOR_BITS-2:0], 1'b1};
        end else begin
            nxt.rem = t[DEN_W-1:0];
            nxt.quo = {cur.quo[FACTOR_BITS-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rgp_sqrt.sv
// Pipelined restoring square root of (sum << 32), two root bits per stage.
`default_nettype none

module rgp_sqrt
    import rgp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [SUM_W-1:0]  in_sum,
    input  wire logic              in_flag,
    output logic                   out_vld,
    output logic [ROOT_W-1:0]      out_root,
    output logic                   out_flag
);

    logic                 vld_reg  [SQ_STG];
    logic                 flag_reg [SQ_STG];
    sq_t                  acc_reg  [SQ_STG];
    logic [SUM_PAD_W-1:0] bits_reg [SQ_STG];

    logic                 vld_in   [SQ_STG];
    logic                 flag_in  [SQ_STG];
    sq_t                  acc_in   [SQ_STG];
    logic [SUM_PAD_W-1:0] bits_in  [SQ_STG];

    for (genvar k = 0; k < SQ_STG; k++) begin : g_stg
        sq_t                  acc_next;
        logic [SUM_PAD_W-1:0] bits_next;

        // Feed stage from the input or the previous stage
        if (k == 0) begin : g_first
            assign vld_in[k]  = in_vld;
            assign flag_in[k] = in_flag;
            assign acc_in[k]  = '0;
            assign bits_in[k] = SUM_PAD_W'(in_sum);
        end else begin : g_rest
            assign vld_in[k]  = vld_reg[k-1];
            assign flag_in[k] = flag_reg[k-1];
            assign acc_in[k]  = acc_reg[k-1];
            assign bits_in[k] = bits_reg[k-1];
        end

        // Consume two bit pairs; zeros follow once the sum is used up
        always_comb begin
            acc_next  = sqrt_step(acc_in[k], bits_in[k][SUM_PAD_W-1 -: 2]);
            acc_next  = sqrt_step(acc_next, bits_in[k][SUM_PAD_W-3 -: 2]);
            bits_next = bits_in[k] << 4;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                flag_reg[k] <= flag_in[k];
                acc_reg[k]  <= acc_next;
                bits_reg[k] <= bits_next;
            end
        end
    end

    assign out_vld  = vld_reg[SQ_STG-1];
    assign out_root = acc_reg[SQ_STG-1].root;
    assign out_flag = flag_reg[SQ_STG-1];

endmodule

`default_nettype wire

>>> rtl/rgp_div.sv
// Pipelined restoring divider for the blend factor, two quotient bits per stage.
`default_nettype none

module rgp_div
    import rgp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_vld,
    input  wire logic [DEN_W-1:0]       in_num,
    input  wire fsel_t                  in_sel,
    input  wire logic [DEN_W-1:0]       den,
    output logic                        out_vld,
    output logic [FACTOR_BITS-1:0]      out_quo,
    output fsel_t                       out_sel
);

    logic  vld_reg [DIV_STG];
    fsel_t sel_reg [DIV_STG];
    dv_t   acc_reg [DIV_STG];

    logic  vld_in  [DIV_STG];
    fsel_t sel_in  [DIV_STG];
    dv_t   acc_in  [DIV_STG];

    for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
        dv_t acc_next;

        // Feed stage from the input or the previous stage
        if (k == 0) begin : g_first
            assign vld_in[k] = in_vld;
            assign sel_in[k] = in_sel;
            assign acc_in[k] = '{rem: in_num, quo: '0};
        end else begin : g_rest
            assign vld_in[k] = vld_reg[k-1];
            assign sel_in[k] = sel_reg[k-1];
            assign acc_in[k] = acc_reg[k-1];
        end

        always_comb begin
            acc_next = div_step(acc_in[k], den);
            acc_next = div_step(acc_next, den);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sel_reg[k] <= sel_in[k];
                acc_reg[k] <= acc_next;
            end
        end
    end

    assign out_vld = vld_reg[DIV_STG-1];
    assign out_quo = acc_reg[DIV_STG-1].quo;
    assign out_sel = sel_reg[DIV_STG-1];

endmodule

`default_nettype wire

>>> rtl/rgp_blend.sv
// Two-stage color blend: per-channel products, then sum, shift and transparent clear.
`default_nettype none

module rgp_blend
    import rgp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_vld,
    input  wire logic [FACTOR_BITS-1:0] in_quo,
    input  wire fsel_t                  in_sel,
    input  wire logic [COLOR_W-1:0]     inner,
    input  wire logic [OCOLOR_W-1:0]    outer,
    output logic                        out_vld,
    output logic [COLOR_W-1:0]          out_rgba
);

    localparam int PROD_W = CH_W + ONE_W;

    logic [ONE_W-1:0]  f;
    logic [ONE_W-1:0]  g;

    logic              p_vld_reg;
    logic [PROD_W-1:0] po_reg [3];
    logic [PROD_W-1:0] pi_reg [4];

    logic              o_vld_reg;
    logic [COLOR_W-1:0] o_rgba_reg;
    logic [COLOR_W-1:0] o_rgba_next;
    logic [CH_W-1:0]    ch [4];

    // Resolve factor and its complement
    always_comb begin
        if (in_sel.one) begin
            f = ONE_W'(1) << FACTOR_BITS;
        end else if (in_sel.zero) begin
            f = '0;
        end else begin
            f = ONE_W'(in_quo);
        end
        g = (ONE_W'(1) << FACTOR_BITS) - f;
    end

    // Stage 1: channel products (alpha has no outer term)
    always_ff @(posedge aclk) begin
        if (en) begin
            po_reg[0] <= PROD_W'(outer[23:16] * f);
            po_reg[1] <= PROD_W'(outer[15:8] * f);
            po_reg[2] <= PROD_W'(outer[7:0] * f);
            pi_reg[0] <= PROD_W'(inner[31:24] * g);
            pi_reg[1] <= PROD_W'(inner[23:16] * g);
            pi_reg[2] <= PROD_W'(inner[15:8] * g);
            pi_reg[3] <= PROD_W'(inner[7:0] * g);
        end
    end

    // Stage 2: sum, truncate, clear fully transparent pixels
    always_comb begin
        logic [PROD_W:0] s;
        for (int c = 0; c < 3; c++) begin
            s     = {1'b0, po_reg[c]} + {1'b0, pi_reg[c]};
            ch[c] = s[FACTOR_BITS +: CH_W];
        end
        ch[3] = pi_reg[3][FACTOR_BITS +: CH_W];
        if (ch[3] == '0) begin
            o_rgba_next = '0;
        end else begin
            o_rgba_next = {ch[3], ch[2], ch[1], ch[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_rgba_reg <= o_rgba_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else if (en) begin
            p_vld_reg <= in_vld;
            o_vld_reg <= p_vld_reg;
        end
    end

    assign out_vld  = o_vld_reg;
    assign out_rgba = o_rgba_reg;

endmodule

`default_nettype wire

>>> rtl/radial_gradient_pixel.sv
// Top level of the radial gradient pixel generator: config registers, front stages, glue.
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid/s_tready   | s_tdata: pixel_x, pixel_y
//  m_      | out | m_tvalid/m_tready   | m_tdata: red, green, blue, alpha
//  cfg_    | in  | cfg_wr_en           | cfg_index, cfg_wdata
//
// One pixel enters per clock while the output is not stalled; the pipeline has 3
// offset/square/sum stages, 14 square root stages (two root bits each), 2 compare
// stages, 8 divider stages (two quotient bits each) and 2 blend stages.
// Reset is synchronous and clears valid bits and configuration to defaults.
// A stall at the output freezes every stage at once; nothing is dropped or repeated.
`default_nettype none

module radial_gradient_pixel
    import rgp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Pixel coordinates in
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [9:0] pixel_x, [19:10] pixel_y
    // Pixel color out
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [COLOR_W-1:0]         m_tdata    // [7:0] red, [15:8] green,
                                                  // [23:16] blue, [31:24] alpha
);

    // Configuration registers
    logic [SIDE_W-1:0]   img_w_reg;
    logic [SIDE_W-1:0]   img_h_reg;
    logic [DENS_W-1:0]   dens_reg;
    logic [COLOR_W-1:0]  inner_reg;
    logic [OCOLOR_W-1:0] outer_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= SIDE_W'(16);
            img_h_reg <= SIDE_W'(16);
            dens_reg  <= DENS_W'(19661);
            inner_reg <= '1;
            outer_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_WIDTH:  img_w_reg <= cfg_wdata[SIDE_W-1:0];
                REG_HEIGHT: img_h_reg <= cfg_wdata[SIDE_W-1:0];
                REG_DENS:   dens_reg  <= cfg_wdata[DENS_W-1:0];
                REG_INNER:  inner_reg <= cfg_wdata[COLOR_W-1:0];
                REG_OUTER:  outer_reg <= cfg_wdata[OCOLOR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Saturate sides and take the doubled radius
    logic [SIDE_W-1:0] w_sat;
    logic [SIDE_W-1:0] h_sat;
    logic [SIDE_W-1:0] r_now;

    assign w_sat = (img_w_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : img_w_reg;
    assign h_sat = (img_h_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : img_h_reg;
    assign r_now = (w_sat < h_sat) ? w_sat : h_sat;

    // Radius-derived terms, settled long before any item reaches them
    logic [SIDE_W-1:0] r_reg;
    logic [DEN_W-1:0]  edge_reg;
    logic [DEN_W-1:0]  den_reg;

    always_ff @(posedge aclk) begin
        r_reg    <= r_now;
        edge_reg <= DEN_W'(r_reg * dens_reg);
        den_reg  <= DEN_W'(r_reg * ((ONE_W'(1) << DENS_W) - ONE_W'(dens_reg)));
    end

    // Global advance: move when the output is empty or being taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage A: absolute doubled offsets
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic signed [OFF_W+1:0] dx_s;
    logic signed [OFF_W+1:0] dy_s;

    assign px   = s_tdata[COORD_W-1:0];
    assign py   = s_tdata[2*COORD_W-1:COORD_W];
    assign dx_s = $signed({2'b00, px, 1'b0}) - $signed({2'b00, w_sat});
    assign dy_s = $signed({2'b00, py, 1'b0}) - $signed({2'b00, h_sat});

    logic             a_vld_reg;
    logic [OFF_W-1:0] adx_reg;
    logic [OFF_W-1:0] ady_reg;
    logic             a_r0_reg;

    // Stage B: squares
    logic             b_vld_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic             b_r0_reg;

    // Stage C: sum of squares
    logic             c_vld_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             c_r0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            adx_reg  <= dx_s[OFF_W+1] ? OFF_W'(-dx_s) : OFF_W'(dx_s);
            ady_reg  <= dy_s[OFF_W+1] ? OFF_W'(-dy_s) : OFF_W'(dy_s);
            a_r0_reg <= (r_now == '0);
            sqx_reg  <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
            sqy_reg  <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
            b_r0_reg <= a_r0_reg;
            sum_reg  <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            c_r0_reg <= b_r0_reg;
        end
    end

    // Doubled distance in Q.16
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    logic              sq_r0;

    rgp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (c_vld_reg),
        .in_sum   (sum_reg),
        .in_flag  (c_r0_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_flag (sq_r0)
    );

    // Stage D: distance past the solid inner edge
    logic              d_vld_reg;
    logic [ROOT_W-1:0] num_reg;
    logic              gt_reg;
    logic              d_r0_reg;

    // Stage E: pick clamps, load divider operand
    logic              e_vld_reg;
    logic [DEN_W-1:0]  e_num_reg;
    fsel_t             e_sel_reg;
    fsel_t             e_sel_next;

    always_comb begin
        e_sel_next.one  = d_r0_reg || (gt_reg && (num_reg >= ROOT_W'(den_reg)));
        e_sel_next.zero = !d_r0_reg && !gt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= sq_vld;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg   <= sq_root - ROOT_W'(edge_reg);
            gt_reg    <= sq_root > ROOT_W'(edge_reg);
            d_r0_reg  <= sq_r0;
            e_num_reg <= num_reg[DEN_W-1:0];
            e_sel_reg <= e_sel_next;
        end
    end

    // Blend factor quotient
    logic                   dv_vld;
    logic [FACTOR_BITS-1:0] dv_quo;
    fsel_t                  dv_sel;

    rgp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (e_vld_reg),
        .in_num  (e_num_reg),
        .in_sel  (e_sel_reg),
        .den     (den_reg),
        .out_vld (dv_vld),
        .out_quo (dv_quo),
        .out_sel (dv_sel)
    );

    // Color blend and output register
    rgp_blend u_blend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (dv_vld),
        .in_quo   (dv_quo),
        .in_sel   (dv_sel),
        .inner    (inner_reg),
        .outer    (outer_reg),
        .out_vld  (m_tvalid),
        .out_rgba (m_tdata)
    );

    // A transparent pixel leaves as all zeros
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31:24] == '0) |-> (m_tdata == '0))
        else $error("transparent pixel with nonzero color");

    // Clamp flags are exclusive
    assert property (@(posedge aclk) disable iff (!aresetn)
        e_vld_reg |-> !(e_sel_reg.one && e_sel_reg.zero))
        else $error("factor forced to both one and zero");

    // A distance past the inner edge leaves a nonzero numerator
    assert property (@(posedge aclk) disable iff (!aresetn)
        d_vld_reg && gt_reg |-> (num_reg != '0))
        else $error("zero numerator past inner edge");

endmodule

`default_nettype wire

>>> tb/radial_gradient_pixel_test.sv
// Self-checking testbench for the radial gradient pixel generator.
`default_nettype none

module radial_gradient_pixel_test;
    import rgp_pkg::*;

    localparam int LATENCY   = 29;
    localparam int CYCLE_CAP = 400000;
    localparam int RAND_PIX  = 1000;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    typedef struct {
        logic [9:0] px;
        logic [9:0] py;
        logic       known;
        rgba_t      color;
    } pix_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [COLOR_W-1:0] m_tdata;

    // Shadow copy of the configuration registers
    logic [10:0] img_w = 11'd16;
    logic [10:0] img_h = 11'd16;
    logic [15:0] dens = 16'd19661;
    logic [31:0] inner_rgba = 32'hFFFFFFFF;
    logic [23:0] outer_rgb = 24'h000000;

    rgba_t color_queue[$];
    int errors = 0;
    int cycles = 0;
    int rx_idle = 0;
    bit calm = 1'b0;
    bit hold_long = 1'b0;
    pix_row_t rows[$];

    radial_gradient_pixel uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("radial_gradient_pixel: mismatch");
            $finish;
        end
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] mix(logic [63:0] o, logic [63:0] i, logic [63:0] f);
        logic [63:0] t;
        t = (o * f + i * (64'd65536 - f)) >> 16;
        return t[7:0];
    endfunction

    // Compute the color of one pixel under the current register values
    function automatic rgba_t pixel_color(logic [9:0] px, logic [9:0] py);
        longint w, h, dx, dy, r;
        logic [63:0] s, dq, edge_q, den, f, q;
        rgba_t c;
        w = (img_w > 1024) ? 1024 : img_w;
        h = (img_h > 1024) ? 1024 : img_h;
        dx = 2 * longint'(px) - w;
        dy = 2 * longint'(py) - h;
        s = dx * dx + dy * dy;
        r = (w < h) ? w : h;
        if (r == 0) begin
            f = 64'd65536;
        end else begin
            dq = int_sqrt(s << 32);
            edge_q = r * dens;
            den = r * (64'd65536 - dens);
            if (dq <= edge_q) begin
                f = 0;
            end else begin
                q = ((dq - edge_q) << 16) / den;
                f = (q > 65536) ? 64'd65536 : q;
            end
        end
        c = '0;
        c.alpha = mix(0, inner_rgba[7:0], f);
        if (c.alpha != 0) begin
            c.red = mix(outer_rgb[23:16], inner_rgba[31:24], f);
            c.green = mix(outer_rgb[15:8], inner_rgba[23:16], f);
            c.blue = mix(outer_rgb[7:0], inner_rgba[15:8], f);
        end
        return c;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WIDTH:  img_w = val[10:0];
            REG_HEIGHT: img_h = val[10:0];
            REG_DENS:   dens = val[15:0];
            REG_INNER:  inner_rgba = val;
            REG_OUTER:  outer_rgb = val[23:0];
            default: ;
        endcase
    endtask

    // Offer one pixel, sometimes after a random idle burst, and queue its color
    task automatic send_pixel(logic [9:0] px, logic [9:0] py, bit known, rgba_t given);
        rgba_t c;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        c = pixel_color(px, py);
        if (known && c != given) begin
            errors++;
            if (errors <= 10)
                $display("table row (%0d,%0d): typed %h, computed %h", px, py, given, c);
        end
        color_queue.push_back(c);
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, py, px};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every expected color has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (color_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Receiver: random idle bursts, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_long) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (rx_idle > 0) begin
            m_tready <= 1'b0;
            rx_idle <= rx_idle - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            rx_idle <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each color transfer against the oldest expectation
    always @(posedge aclk) begin
        rgba_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (color_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected color %h", got);
            end else begin
                want = color_queue.pop_front();
                if (got.red != want.red || got.green != want.green ||
                    got.blue != want.blue || got.alpha != want.alpha) begin
                    errors++;
                    if (errors <= 10) $display("color: expected %h, got %h", want, got);
                end
            end
        end
    end

    initial begin
        int i, k;
        rgba_t none;
        none = '0;
        // Directed rows: center, corners, extremes; colors typed where obvious
        rows.push_back('{10'd8, 10'd8, 1'b1, rgba_t'(32'hFFFFFFFF)});
        rows.push_back('{10'd0, 10'd0, 1'b1, none});
        rows.push_back('{10'd1023, 10'd1023, 1'b1, none});
        rows.push_back('{10'd0, 10'd1023, 1'b1, none});
        rows.push_back('{10'd1023, 10'd0, 1'b1, none});
        rows.push_back('{10'd15, 10'd8, 1'b0, none});
        rows.push_back('{10'd8, 10'd13, 1'b0, none});
        rows.push_back('{10'd11, 10'd11, 1'b0, none});
        rows.push_back('{10'd682, 10'd341, 1'b0, none});
        rows.push_back('{10'd341, 10'd682, 1'b0, none});

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[j]) send_pixel(rows[j].px, rows[j].py, rows[j].known, rows[j].color);
        drain();

        // Extremes: largest image, zero size, oversize, densities at ends
        write_reg(REG_WIDTH, 1024);
        write_reg(REG_HEIGHT, 1024);
        write_reg(REG_DENS, 0);
        write_reg(REG_INNER, 32'h12345678);
        write_reg(REG_OUTER, 24'hFFFFFF);
        send_pixel(10'd512, 10'd512, 1'b1, rgba_t'(32'h78563412));
        send_pixel(10'd0, 10'd0, 1'b0, none);
        send_pixel(10'd1023, 10'd512, 1'b0, none);
        drain();
        write_reg(REG_DENS, 65535);
        send_pixel(10'd700, 10'd300, 1'b0, none);
        send_pixel(10'd512, 10'd512, 1'b0, none);
        drain();
        write_reg(REG_WIDTH, 0);
        send_pixel(10'd5, 10'd5, 1'b1, none);
        drain();
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 1);
        send_pixel(10'd0, 10'd0, 1'b0, none);
        send_pixel(10'd1023, 10'd0, 1'b0, none);
        drain();

        // Random phases, each with fresh registers; most phases draw one side up to 2047, the other up to 64
        for (k = 0; k < 8; k++) begin
            if (k == 7) calm = 1'b1;
            write_reg(REG_WIDTH, (k % 3 == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64));
            write_reg(REG_HEIGHT, (k % 3 == 1) ? $urandom_range(0, 2047) : $urandom_range(1, 64));
            write_reg(REG_DENS, (k == 2) ? 0 : (k == 5) ? 65535 : $urandom_range(0, 65535));
            write_reg(REG_INNER, $urandom());
            write_reg(REG_OUTER, $urandom_range(0, 24'hFFFFFF));
            if (k == 3) begin
                fork
                    begin
                        hold_long = 1'b1;
                        repeat (120) @(posedge aclk);
                        hold_long = 1'b0;
                    end
                join_none
            end
            for (i = 0; i < RAND_PIX / 8; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                               1'b0, none);
                else
                    send_pixel(10'($urandom_range(0, img_w > 70 ? 1023 : img_w + 2)),
                               10'($urandom_range(0, img_h > 70 ? 1023 : img_h + 2)),
                               1'b0, none);
            end
            drain();
        end

        if (errors == 0 && color_queue.size() == 0) begin
            $display("radial_gradient_pixel: match");
        end else begin
            $display("radial_gradient_pixel: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/rgp_pkg.sv
rtl/rgp_sqrt.sv
rtl/rgp_div.sv
rtl/rgp_blend.sv
rtl/radial_gradient_pixel.sv
tb/radial_gradient_pixel_test.sv
